// ----- hw/rtl/mvbu_pkg.sv -----
// Shared types and constants for the mesh vertex bit unpacker.
// Used by mvbu_front, mvbu_back and mesh_vertex_bit_unpacker; no dependencies.

package mvbu_pkg;

   // Byte queue between the front and back parts
   localparam int QueueDepth = 4;
   localparam int QueueAw    = 2;

   // Register indexes of the configuration port
   typedef enum logic [1:0] {
      CSR_FLAG_BITS  = 2'd0,
      CSR_COORD_BITS = 2'd1,
      CSR_COMP_BITS  = 2'd2,
      CSR_COMP_COUNT = 2'd3
   } csr_index_type;

   // Live configuration seen by the back part
   typedef struct packed {
      logic [3:0] flag_bits;
      logic [5:0] coord_bits;
      logic [4:0] comp_bits;
      logic [3:0] comp_count;
   } cfg_type;

   // Head of the byte queue
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } byte_slot_type;

endpackage

// ----- hw/rtl/mvbu_front.sv -----
// Front part of the mesh vertex bit unpacker: accepts stream bytes into a short queue.
// Depends on mvbu_pkg.

module mvbu_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [7:0] data_byte
   input  logic                   pop,
   output mvbu_pkg::byte_slot_type head
);
   import mvbu_pkg::*;

   logic [7:0]         slot_ff [QueueDepth];
   logic [QueueAw-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueueAw-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueueAw:0]   count_ff, count_in;
   logic               push;
   logic               pull;

   // Accept while a slot is free
   assign req_tready = (count_ff != (QueueAw+1)'(QueueDepth));
   assign push       = req_tvalid && req_tready;
   assign pull       = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.data  = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pull ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pull) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pull) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the accepted byte
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_tdata;
      end
   end

endmodule

// ----- hw/rtl/mvbu_back.sv -----
// Back part of the mesh vertex bit unpacker: slices queued bytes into record fields.
// Depends on mvbu_pkg; fed by mvbu_front.

module mvbu_back #(
   parameter int MAX_COMPONENTS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mvbu_pkg::cfg_type       cfg,
   input  mvbu_pkg::byte_slot_type head,
   output logic                    pop,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [39:0]             rsp_tdata,  // [31:0] field_value, [35:32] field_position
   output logic                    rsp_tuser,  // [0] end_of_record
   output logic                    rsp_tlast   // last_of_run
);
   import mvbu_pkg::*;

   localparam int PosWidth = $clog2(MAX_COMPONENTS + 3);

   // Bit slicing state
   logic [7:0]          sh_ff, sh_in;
   logic [3:0]          rem_ff, rem_in;
   logic [31:0]         partial_ff, partial_in;
   logic [5:0]          bc_ff, bc_in;
   logic [PosWidth-1:0] pos_ff, pos_in;

   // Output register
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_value_ff, out_value_in;
   logic [3:0]  out_pos_ff, out_pos_in;
   logic        out_eor_ff, out_eor_in;
   logic        out_last_ff, out_last_in;

   logic [5:0]          coord_w, comp_w, width, need, next_w, num_w;
   logic [PosWidth-1:0] eff_pos, last_pos;
   logic [PosWidth+3:0] pos_wide;
   logic [3:0]          take, rem_left;
   logic [7:0]          bits;
   logic [31:0]         grown, value;
   logic                done, ends, step_en, load_en;

   // Effective widths, record length and current field
   always_comb begin
      if (cfg.coord_bits == 6'd0) begin
         coord_w = 6'd1;
      end else if (cfg.coord_bits > 6'd32) begin
         coord_w = 6'd32;
      end else begin
         coord_w = cfg.coord_bits;
      end
      comp_w = (cfg.comp_bits == 5'd0) ? 6'd1 : {1'b0, cfg.comp_bits};

      num_w = (cfg.comp_count == 4'd0) ? 6'd1 : {2'b00, cfg.comp_count};
      if (num_w > 6'(MAX_COMPONENTS)) begin
         num_w = 6'(MAX_COMPONENTS);
      end
      last_pos = PosWidth'(num_w + 6'd2);

      eff_pos = ((pos_ff == '0) && (cfg.flag_bits == 4'd0)) ? PosWidth'(1) : pos_ff;
      if (eff_pos == '0) begin
         width = {2'b00, cfg.flag_bits};
      end else if (eff_pos <= PosWidth'(2)) begin
         width = coord_w;
      end else begin
         width = comp_w;
      end
   end

   // Take as many bits as the field needs or the byte still holds
   always_comb begin
      need  = (bc_ff >= width) ? 6'd1 : width - bc_ff;
      done  = (need <= {2'b00, rem_ff});
      take  = done ? need[3:0] : rem_ff;
      bits  = sh_ff >> (4'd8 - take);
      grown = (partial_ff << take) | {24'd0, bits};
      value = (width >= 6'd32) ? grown : (grown & ~(32'hFFFF_FFFF << width));
      ends  = (eff_pos >= last_pos);
      rem_left = (done && ends) ? 4'd0 : rem_ff - take;
      // Field after this one in the same record is a coordinate or a component, never the flag
      next_w   = (eff_pos <= PosWidth'(1)) ? coord_w : comp_w;
      pos_wide = {4'd0, eff_pos};
   end

   assign step_en = (rem_ff != 4'd0) && (!out_valid_ff || rsp_tready);
   assign load_en = head.valid && ((rem_ff == 4'd0) || (step_en && (rem_left == 4'd0)));
   assign pop     = load_en;

   // Next state of the slicer and the output register
   always_comb begin
      sh_in        = sh_ff;
      rem_in       = rem_ff;
      partial_in   = partial_ff;
      bc_in        = bc_ff;
      pos_in       = pos_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_value_in = out_value_ff;
      out_pos_in   = out_pos_ff;
      out_eor_in   = out_eor_ff;
      out_last_in  = out_last_ff;
      if (step_en) begin
         sh_in  = sh_ff << take;
         rem_in = rem_left;
         if (done) begin
            partial_in   = '0;
            bc_in        = '0;
            pos_in       = ends ? '0 : eff_pos + 1'b1;
            out_valid_in = 1'b1;
            out_value_in = value;
            out_pos_in   = pos_wide[3:0];
            out_eor_in   = ends;
            out_last_in  = ends || (next_w > {2'b00, rem_left});
         end else begin
            partial_in = grown;
            bc_in      = bc_ff + 6'(take);
            pos_in     = eff_pos;
         end
      end
      // Load the next byte once the current one is used up
      if (load_en) begin
         sh_in  = head.data;
         rem_in = 4'd8;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sh_ff        <= '0;
         rem_ff       <= '0;
         partial_ff   <= '0;
         bc_ff        <= '0;
         pos_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         sh_ff        <= sh_in;
         rem_ff       <= rem_in;
         partial_ff   <= partial_in;
         bc_ff        <= bc_in;
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Result payload holds without reset
   always_ff @(posedge clock) begin
      out_value_ff <= out_value_in;
      out_pos_ff   <= out_pos_in;
      out_eor_ff   <= out_eor_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_pos_ff, out_value_ff};
   assign rsp_tuser  = out_eor_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ----- hw/rtl/mesh_vertex_bit_unpacker.sv -----
// Top level of the mesh vertex bit unpacker: configuration registers, front and back.
// Depends on mvbu_pkg, mvbu_front and mvbu_back.
//
// Usage:
//   req_*  carries the packed vertex stream, one byte per transaction.
//   rsp_*  carries one transaction per completed field: value, position in the
//          record (0 flag, 1 x, 2 y, 3 and up colour components), end_of_record
//          on tuser and tlast on the last field completed by one input byte.
//   csr_*  writes flag_bits, coord_bits, comp_bits and the component count by
//          index; write only while no byte is in flight. Always ready.
// Throughput: the slicer takes a separate step for each field a byte completes and
// another when the byte's remaining bits open a field it does not complete; a byte
// that ends a record drops its remaining bits. One byte per cycle holds, while the
// result side is not stalled, when every field boundary falls on a byte boundary.
// With the slicer idle, the first field of an accepted byte is registered in the
// slicer load and then in the output register before it is valid on rsp.
// A four-entry byte queue keeps req_tready high while rsp_tready is low, until
// the queue fills; a stalled result holds in the output register.
// Reset (synchronous) empties the queue, drops any partial field, restarts at
// the beginning of a record and loads configuration defaults 0, 8, 8 and 3.

module mesh_vertex_bit_unpacker #(
   parameter int MAX_COMPONENTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] field_value, [35:32] field_position, [39:36] zero
   output logic        rsp_tuser,   // [0] end_of_record
   output logic        rsp_tlast,   // last_of_run
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [5:0]  csr_data
);
   import mvbu_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   byte_slot_type head;
   logic          pop;

   assign csr_ready = 1'b1;

   // Decode configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_FLAG_BITS:  cfg_in.flag_bits  = csr_data[3:0];
            CSR_COORD_BITS: cfg_in.coord_bits = csr_data;
            CSR_COMP_BITS:  cfg_in.comp_bits  = csr_data[4:0];
            CSR_COMP_COUNT: cfg_in.comp_count = csr_data[3:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flag_bits  <= 4'd0;
         cfg_ff.coord_bits <= 6'd8;
         cfg_ff.comp_bits  <= 5'd8;
         cfg_ff.comp_count <= 4'd3;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mvbu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .pop        (pop),
      .head       (head)
   );

   mvbu_back #(
      .MAX_COMPONENTS (MAX_COMPONENTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- verif/tb_mesh_vertex_bit_unpacker.sv -----
// Self-checking testbench for mesh_vertex_bit_unpacker: directed table, then random phases.
// Depends on mvbu_pkg and the RTL of the block; predicts fields from a local bit slicer or from typed table rows.

`timescale 1ns / 100ps

module tb_mesh_vertex_bit_unpacker;
   import mvbu_pkg::*;

   localparam int MaxComponents = 8;
   localparam int CycleLimit    = 200000;
   localparam int SettleCycles  = 16;

   // One completed field as seen on the result stream
   typedef struct {
      logic [31:0] value;
      logic [3:0]  position;
      logic        end_of_record;
      logic        last_of_run;
   } field_type;

   typedef enum {ROW_CSR, ROW_BYTE} row_kind_type;
   typedef enum {CHK_MODEL, CHK_TYPED, CHK_SILENT} row_check_type;

   typedef struct {
      row_kind_type  kind;
      csr_index_type index;
      logic [5:0]    wdata;
      logic [7:0]    data;
      row_check_type check;
      field_type     typed;
   } row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [5:0]  csr_data;

   // Shadow registers and slicer state of the predictor
   int unsigned sh_flag_bits;
   int unsigned sh_coord_bits;
   int unsigned sh_comp_bits;
   int unsigned sh_comp_count;
   logic [31:0] gather_value;
   int unsigned gather_count;
   int unsigned gather_position;

   field_type   byte_fields[$];
   field_type   fields_due[$];
   row_type     stim_rows[$];

   int          error_count = 0;
   int          cycle_count = 0;
   int          req_idle_pct;
   int          rsp_idle_pct;
   int          rsp_hold_count;

   mesh_vertex_bit_unpacker #(
      .MAX_COMPONENTS(MaxComponents)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("tb_mesh_vertex_bit_unpacker: errors");
         $finish;
      end
   end

   // Width of the field at a record position, with zero coordinate and component widths and oversize coordinates folded
   function automatic int unsigned width_at(input int unsigned position);
      int unsigned w;
      if (position == 0)
         return sh_flag_bits;
      if (position <= 2) begin
         w = (sh_coord_bits > 32) ? 32 : sh_coord_bits;
      end else begin
         w = sh_comp_bits;
      end
      if (w == 0)
         w = 1;
      return w;
   endfunction

   // Shift one byte in MSB first; collect the fields it completes in byte_fields
   task automatic slice_byte(input logic [7:0] data);
      int unsigned last_position;
      int unsigned w;
      int          i;
      bit          ends;
      field_type   f;
      last_position = sh_comp_count;
      if (last_position < 1)
         last_position = 1;
      if (last_position > MaxComponents)
         last_position = MaxComponents;
      last_position += 2;
      byte_fields.delete();
      for (i = 7; i >= 0; i--) begin
         if (gather_position == 0 && sh_flag_bits == 0)
            gather_position = 1;
         w = width_at(gather_position);
         gather_value = {gather_value[30:0], data[i]};
         gather_count++;
         if (gather_count < w)
            continue;
         f.value = (w >= 32) ? gather_value : (gather_value & ((32'd1 << w) - 32'd1));
         ends = (gather_position >= last_position);
         f.position = gather_position[3:0];
         f.end_of_record = ends;
         f.last_of_run = 1'b0;
         byte_fields.push_back(f);
         gather_value = '0;
         gather_count = 0;
         if (ends) begin
            gather_position = 0;
            break;
         end
         gather_position++;
      end
      if (byte_fields.size() > 0)
         byte_fields[byte_fields.size() - 1].last_of_run = 1'b1;
   endtask

   // Write one register and mirror it into the shadow copy
   task automatic csr_write(input csr_index_type index, input logic [5:0] wdata);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = wdata;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_FLAG_BITS:  sh_flag_bits  = wdata[3:0];
         CSR_COORD_BITS: sh_coord_bits = wdata[5:0];
         CSR_COMP_BITS:  sh_comp_bits  = wdata[4:0];
         CSR_COMP_COUNT: sh_comp_count = wdata[3:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Offer one byte until accepted, then queue what it should produce
   task automatic send_byte(input logic [7:0] data, input row_check_type check,
                            input field_type typed);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid = 1'b0;
         req_tdata  = 8'($urandom_range(255));
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = data;
      do @(posedge clock); while (!req_tready);
      slice_byte(data);
      case (check)
         CHK_MODEL:  foreach (byte_fields[k]) fields_due.push_back(byte_fields[k]);
         CHK_TYPED:  fields_due.push_back(typed);
         CHK_SILENT: ;
         default: ;
      endcase
   endtask

   // Stop offering, wait for every expected field, then let silent bytes drain
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (fields_due.size() != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic add_csr(input csr_index_type index, input logic [5:0] wdata);
      row_type r;
      r.kind  = ROW_CSR;
      r.index = index;
      r.wdata = wdata;
      r.data  = '0;
      r.check = CHK_MODEL;
      r.typed = '{default: '0};
      stim_rows.push_back(r);
   endtask

   task automatic add_byte(input logic [7:0] data, input row_check_type check,
                           input logic [31:0] value = '0, input logic [3:0] position = '0,
                           input logic end_of_record = 1'b0);
      row_type r;
      r.kind  = ROW_BYTE;
      r.index = CSR_FLAG_BITS;
      r.wdata = '0;
      r.data  = data;
      r.check = check;
      r.typed.value         = value;
      r.typed.position      = position;
      r.typed.end_of_record = end_of_record;
      r.typed.last_of_run   = 1'b1;
      stim_rows.push_back(r);
   endtask

   function automatic int pick_setting(input int lo, input int hi);
      if ($urandom_range(99) < 15)
         return $urandom_range(63);
      return $urandom_range(hi, lo);
   endfunction

   // Compare each accepted field with the oldest expectation
   always @(posedge clock) begin : check_fields
      field_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (fields_due.size() == 0) begin
            $display("%0t: unexpected field, expected none, actual value %h position %0d eor %b last %b",
                     $time, rsp_tdata[31:0], rsp_tdata[35:32], rsp_tuser, rsp_tlast);
            error_count++;
         end else begin
            want = fields_due.pop_front();
            if (rsp_tdata[31:0] !== want.value) begin
               $display("%0t: field_value expected %h actual %h",
                        $time, want.value, rsp_tdata[31:0]);
               error_count++;
            end
            if (rsp_tdata[35:32] !== want.position) begin
               $display("%0t: field_position expected %0d actual %0d",
                        $time, want.position, rsp_tdata[35:32]);
               error_count++;
            end
            if (rsp_tdata[39:36] !== 4'd0) begin
               $display("%0t: tdata padding expected 0 actual %h", $time, rsp_tdata[39:36]);
               error_count++;
            end
            if (rsp_tuser !== want.end_of_record) begin
               $display("%0t: end_of_record expected %b actual %b",
                        $time, want.end_of_record, rsp_tuser);
               error_count++;
            end
            if (rsp_tlast !== want.last_of_run) begin
               $display("%0t: last_of_run expected %b actual %b",
                        $time, want.last_of_run, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // Result side: random backpressure, one long hold-off per request
   initial begin
      int holds_done;
      holds_done = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_count != holds_done) begin
            holds_done++;
            rsp_tready = 1'b0;
            repeat (120) @(negedge clock);
         end
         rsp_tready = ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Main stimulus
   initial begin : stimulus
      int        phase;
      int        n;
      field_type no_field;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      csr_valid      = 1'b0;
      csr_index      = CSR_FLAG_BITS;
      csr_data       = '0;
      req_idle_pct   = 20;
      rsp_idle_pct   = 20;
      rsp_hold_count = 0;
      no_field       = '{default: '0};

      // Predictor starts from the reset state
      sh_flag_bits    = 0;
      sh_coord_bits   = 8;
      sh_comp_bits    = 8;
      sh_comp_count   = 3;
      gather_value    = '0;
      gather_count    = 0;
      gather_position = 0;

      // Reset defaults: no flag, 8-bit x, y and three 8-bit components
      add_byte(8'h00, CHK_TYPED, 32'h0000_0000, 4'd1);
      add_byte(8'hFF, CHK_TYPED, 32'h0000_00FF, 4'd2);
      add_byte(8'h80, CHK_TYPED, 32'h0000_0080, 4'd3);
      add_byte(8'h01, CHK_TYPED, 32'h0000_0001, 4'd4);
      add_byte(8'hA5, CHK_TYPED, 32'h0000_00A5, 4'd5, 1'b1);

      // Narrowest fields: one byte completes eight fields; two records close
      add_csr(CSR_FLAG_BITS, 6'd1);
      add_csr(CSR_COORD_BITS, 6'd1);
      add_csr(CSR_COMP_BITS, 6'd1);
      add_csr(CSR_COMP_COUNT, 6'd8);
      add_byte(8'hFF, CHK_MODEL);
      add_byte(8'h5A, CHK_MODEL);
      add_byte(8'h00, CHK_MODEL);
      add_byte(8'hC3, CHK_MODEL);

      // Wide fields: 8-bit flag, 32-bit coordinates, one 16-bit component
      add_csr(CSR_FLAG_BITS, 6'd8);
      add_csr(CSR_COORD_BITS, 6'd32);
      add_csr(CSR_COMP_BITS, 6'd16);
      add_csr(CSR_COMP_COUNT, 6'd1);
      add_byte(8'hFF, CHK_TYPED, 32'h0000_00FF, 4'd0);
      add_byte(8'hFF, CHK_SILENT);
      add_byte(8'hFF, CHK_SILENT);
      add_byte(8'hFF, CHK_SILENT);
      add_byte(8'hFF, CHK_TYPED, 32'hFFFF_FFFF, 4'd1);
      add_byte(8'h00, CHK_SILENT);
      add_byte(8'h00, CHK_SILENT);
      add_byte(8'h00, CHK_SILENT);
      add_byte(8'h00, CHK_TYPED, 32'h0000_0000, 4'd2);
      add_byte(8'h12, CHK_SILENT);
      add_byte(8'h34, CHK_TYPED, 32'h0000_1234, 4'd3, 1'b1);

      // Wide flag, zero widths and zero component count
      add_csr(CSR_FLAG_BITS, 6'd15);
      add_csr(CSR_COORD_BITS, 6'd0);
      add_csr(CSR_COMP_BITS, 6'd0);
      add_csr(CSR_COMP_COUNT, 6'd0);
      add_byte(8'hFF, CHK_MODEL);
      add_byte(8'hFE, CHK_MODEL);
      add_byte(8'hC0, CHK_MODEL);

      // Oversize coordinate, widest component, too many components; record left open
      add_csr(CSR_FLAG_BITS, 6'd0);
      add_csr(CSR_COORD_BITS, 6'd63);
      add_csr(CSR_COMP_BITS, 6'd31);
      add_csr(CSR_COMP_COUNT, 6'd15);
      add_byte(8'h96, CHK_MODEL);
      add_byte(8'h3C, CHK_MODEL);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Walk the directed table
      foreach (stim_rows[r]) begin
         if (stim_rows[r].kind == ROW_CSR) begin
            wait_drained();
            csr_write(stim_rows[r].index, stim_rows[r].wdata);
         end else begin
            send_byte(stim_rows[r].data, stim_rows[r].check, stim_rows[r].typed);
         end
      end

      // Random phases; settings change between phases, often in mid-record
      for (phase = 0; phase < 12; phase++) begin
         wait_drained();
         case (phase)
            0: begin
               csr_write(CSR_FLAG_BITS, 6'd1);
               csr_write(CSR_COORD_BITS, 6'd1);
               csr_write(CSR_COMP_BITS, 6'd1);
               csr_write(CSR_COMP_COUNT, 6'd8);
            end
            1: begin
               csr_write(CSR_FLAG_BITS, 6'd8);
               csr_write(CSR_COORD_BITS, 6'd32);
               csr_write(CSR_COMP_BITS, 6'd16);
               csr_write(CSR_COMP_COUNT, 6'd8);
            end
            default: begin
               csr_write(CSR_FLAG_BITS, 6'(pick_setting(0, 8)));
               csr_write(CSR_COORD_BITS, 6'(pick_setting(1, 32)));
               csr_write(CSR_COMP_BITS, 6'(pick_setting(1, 16)));
               csr_write(CSR_COMP_COUNT, 6'(pick_setting(1, 8)));
            end
         endcase

         // Hold the result side off while bytes keep coming; keep one phase gap-free
         if (phase == 0)
            rsp_hold_count++;
         req_idle_pct = (phase == 3) ? 0 : 20;
         rsp_idle_pct = (phase == 3) ? 0 : 20;

         for (n = 0; n < 34; n++)
            send_byte(8'($urandom_range(255)), CHK_MODEL, no_field);
      end

      wait_drained();
      if (error_count == 0) begin
         $display("tb_mesh_vertex_bit_unpacker: clean");
      end else begin
         $display("tb_mesh_vertex_bit_unpacker: errors");
      end
      $finish;
   end

endmodule
